// ----- rtl/core/bbcc_pkg.sv -----
// Package for the buck/boost charge controller: field widths, fixed limits,
// register indexes and register reset values.
// No dependencies; every other file of the block uses it by scoped names.
package bbcc_pkg;

  localparam int unsigned MV_W      = 16;
  localparam int unsigned SENSE_W   = 12;
  localparam int unsigned TEMP_W    = 19;
  localparam int unsigned PULSE_W   = 16;
  localparam int unsigned OFF_W     = 32;
  localparam int unsigned PHASE_W   = 7;
  localparam int unsigned SETTLE_W  = 5;
  localparam int unsigned BEST_W    = 13;
  localparam int unsigned CUR_W     = 14;
  localparam int unsigned APB_AW    = 5;
  localparam int unsigned APB_DW    = 32;

  localparam logic signed [TEMP_W-1:0] TEMP_LIMIT_MC    = 19'sd80000;
  localparam logic [MV_W-1:0]          BATTERY_FLOOR_MV = 16'd4000;
  localparam logic signed [CUR_W-1:0]  SENSE_OFFSET_MV  = 14'sd20;
  localparam logic signed [CUR_W-1:0]  LOW_CURRENT_MV   = 14'sd50;
  localparam logic [MV_W:0]            BOOST_MARGIN_MV  = 17'd100;
  localparam logic [SETTLE_W-1:0]      SETTLE_TICKS     = 5'd25;
  localparam logic signed [CUR_W-1:0]  NEAR_TARGET_MV   = 14'sd10;
  localparam logic [PHASE_W-1:0]       PHASE_LAST       = 7'd99;

  typedef enum logic [2:0] {
    REG_TARGET_CURRENT = 3'd0,
    REG_PWM_FULL_SCALE = 3'd1,
    REG_BATTERY_HIGH   = 3'd2,
    REG_BALANCE_HIGH   = 3'd3,
    REG_INPUT_MIN      = 3'd4,
    REG_START_HOLD     = 3'd5,
    REG_OUTPUT_MIN     = 3'd6
  } cfg_idx_t;

  localparam logic [SENSE_W-1:0] RST_TARGET_CURRENT = 12'd300;
  localparam logic [MV_W-1:0]    RST_PWM_FULL_SCALE = 16'd1000;
  localparam logic [MV_W-1:0]    RST_BATTERY_HIGH   = 16'd4200;
  localparam logic [MV_W-1:0]    RST_BALANCE_HIGH   = 16'd4200;
  localparam logic [MV_W-1:0]    RST_INPUT_MIN      = 16'd4500;
  localparam logic [MV_W-1:0]    RST_START_HOLD     = 16'd5500;
  localparam logic [MV_W-1:0]    RST_OUTPUT_MIN     = 16'd3300;

endpackage

// ----- rtl/core/bbcc_in_if.sv -----
// Request channel into the charge controller: one set of tick measurements.
// Depends on bbcc_pkg for the field widths.
interface bbcc_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [bbcc_pkg::MV_W-1:0]              input_mv;
  logic [bbcc_pkg::MV_W-1:0]              battery_mv;
  logic [bbcc_pkg::MV_W-1:0]              balance_mv;
  logic [bbcc_pkg::SENSE_W-1:0]           sense_mv;
  logic signed [bbcc_pkg::TEMP_W-1:0]     chip_temp_mc;
  logic                                   output_wanted;

  modport source (output valid, input ready, output input_mv, battery_mv, balance_mv,
                  sense_mv, chip_temp_mc, output_wanted);
  modport sink   (input valid, output ready, input input_mv, battery_mv, balance_mv,
                  sense_mv, chip_temp_mc, output_wanted);
endinterface

// ----- rtl/core/bbcc_out_if.sv -----
// Result channel out of the charge controller: pulses, enables and off count.
// Depends on bbcc_pkg for the field widths.
interface bbcc_out_if;
  logic                           valid;
  logic                           ready;
  logic [bbcc_pkg::PULSE_W-1:0]   buck_pulse;
  logic [bbcc_pkg::PULSE_W-1:0]   boost_pulse;
  logic                           converter_on;
  logic                           charging;
  logic [bbcc_pkg::OFF_W-1:0]     off_ticks;

  modport source (output valid, input ready, output buck_pulse, boost_pulse,
                  converter_on, charging, off_ticks);
  modport sink   (input valid, output ready, input buck_pulse, boost_pulse,
                  converter_on, charging, off_ticks);
endinterface

// ----- rtl/core/buck_boost_charge_controller.sv -----
// Top level of the buck/boost charge controller: APB register file, input
// register, tick logic with its state, and result register.
// Depends on bbcc_pkg, bbcc_in_if and bbcc_out_if.

// Each request carries one control tick's measurements and yields exactly one
// result. A request is captured in an input register; as it leaves that
// register, the tick logic (limit checks, settle counter, pulse search and
// dither, mode choice, off counter) updates the controller state and loads
// the result register. Throughput is one request per clock while the sink
// takes results; the only loop is the controller state update. While a
// finished result waits for the sink, the input register can still take one
// more request; after that the input stalls until the sink takes the result.
// Registers sit at byte addresses 4*i (target current, PWM full scale, battery
// high, balance high, input minimum, start hold, output minimum). They are to be
// written only while the block is idle; the block itself does not enforce it.
module buck_boost_charge_controller (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bbcc_pkg::APB_AW-1:0]       paddr,
  input  logic [bbcc_pkg::APB_DW-1:0]       pwdata,
  output logic [bbcc_pkg::APB_DW-1:0]       prdata,
  output logic                              pready,
  bbcc_in_if.sink                           in_ch,
  bbcc_out_if.source                        out_ch
);

  // Configuration registers.
  logic [bbcc_pkg::SENSE_W-1:0] target_r;
  logic [bbcc_pkg::MV_W-1:0]    full_r;
  logic [bbcc_pkg::MV_W-1:0]    bat_high_r;
  logic [bbcc_pkg::MV_W-1:0]    bal_high_r;
  logic [bbcc_pkg::MV_W-1:0]    in_min_r;
  logic [bbcc_pkg::MV_W-1:0]    start_hold_r;
  logic [bbcc_pkg::MV_W-1:0]    out_min_r;

  bbcc_pkg::cfg_idx_t cfg_idx;
  logic               cfg_wr;

  // Input register.
  logic                               s0_valid_r;
  logic [bbcc_pkg::MV_W-1:0]          s0_vin_r;
  logic [bbcc_pkg::MV_W-1:0]          s0_vbat_r;
  logic [bbcc_pkg::MV_W-1:0]          s0_vbal_r;
  logic [bbcc_pkg::SENSE_W-1:0]       s0_sense_r;
  logic signed [bbcc_pkg::TEMP_W-1:0] s0_temp_r;
  logic                               s0_wanted_r;

  // Controller state.
  logic [bbcc_pkg::PHASE_W-1:0]       phase_r;
  logic [bbcc_pkg::SETTLE_W-1:0]      settle_r;
  logic [bbcc_pkg::PULSE_W-1:0]       buck_r;
  logic [bbcc_pkg::PULSE_W-1:0]       boost_r;
  logic signed [bbcc_pkg::BEST_W-1:0] best_cur_r;
  logic [bbcc_pkg::PULSE_W-1:0]       best_pulse_r;
  logic [bbcc_pkg::OFF_W-1:0]         off_cnt_r;

  // Result register.
  logic                         out_valid_r;
  logic [bbcc_pkg::PULSE_W-1:0] out_buck_r;
  logic [bbcc_pkg::PULSE_W-1:0] out_boost_r;
  logic                         out_conv_r;
  logic                         out_chg_r;
  logic [bbcc_pkg::OFF_W-1:0]   out_off_r;

  // Tick logic.
  logic                               s0_adv;
  logic [bbcc_pkg::PHASE_W-1:0]       phase_nxt;
  logic                               charging;
  logic                               settled;
  logic [bbcc_pkg::SETTLE_W-1:0]      settle_nxt;
  logic signed [bbcc_pkg::CUR_W-1:0]  cur;
  logic signed [bbcc_pkg::CUR_W-1:0]  tgt;
  logic [bbcc_pkg::PULSE_W-1:0]       p;
  logic [bbcc_pkg::PULSE_W-1:0]       p_inc;
  logic [bbcc_pkg::PULSE_W-1:0]       p_dec;
  logic [bbcc_pkg::PULSE_W+1:0]       p1;
  logic [bbcc_pkg::PULSE_W+1:0]       p1x3;
  logic                               low_room;
  logic                               climb_room;
  logic [bbcc_pkg::PULSE_W-1:0]       p_new;
  logic signed [bbcc_pkg::CUR_W-1:0]  bc;
  logic [bbcc_pkg::PULSE_W-1:0]       bp;
  logic                               boost_mode;
  logic [bbcc_pkg::PULSE_W-1:0]       buck_nxt;
  logic [bbcc_pkg::PULSE_W-1:0]       boost_nxt;
  logic                               conv_on;
  logic [bbcc_pkg::OFF_W-1:0]         off_nxt;

  // ---------------------------------------------------------------------
  // APB register file. pready is tied high, so a write lands at the access
  // cycle. The byte offset bits are ignored.
  // ---------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_idx = bbcc_pkg::cfg_idx_t'(paddr[bbcc_pkg::APB_AW-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r     <= bbcc_pkg::RST_TARGET_CURRENT;
      full_r       <= bbcc_pkg::RST_PWM_FULL_SCALE;
      bat_high_r   <= bbcc_pkg::RST_BATTERY_HIGH;
      bal_high_r   <= bbcc_pkg::RST_BALANCE_HIGH;
      in_min_r     <= bbcc_pkg::RST_INPUT_MIN;
      start_hold_r <= bbcc_pkg::RST_START_HOLD;
      out_min_r    <= bbcc_pkg::RST_OUTPUT_MIN;
    end else if (cfg_wr) begin
      case (cfg_idx)
        bbcc_pkg::REG_TARGET_CURRENT: target_r     <= pwdata[bbcc_pkg::SENSE_W-1:0];
        bbcc_pkg::REG_PWM_FULL_SCALE: full_r       <= pwdata[bbcc_pkg::MV_W-1:0];
        bbcc_pkg::REG_BATTERY_HIGH:   bat_high_r   <= pwdata[bbcc_pkg::MV_W-1:0];
        bbcc_pkg::REG_BALANCE_HIGH:   bal_high_r   <= pwdata[bbcc_pkg::MV_W-1:0];
        bbcc_pkg::REG_INPUT_MIN:      in_min_r     <= pwdata[bbcc_pkg::MV_W-1:0];
        bbcc_pkg::REG_START_HOLD:     start_hold_r <= pwdata[bbcc_pkg::MV_W-1:0];
        bbcc_pkg::REG_OUTPUT_MIN:     out_min_r    <= pwdata[bbcc_pkg::MV_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data is a plain decode of the address; the unused slot reads zero.
  always_comb begin
    prdata = '0;
    case (cfg_idx)
      bbcc_pkg::REG_TARGET_CURRENT: prdata = {20'd0, target_r};
      bbcc_pkg::REG_PWM_FULL_SCALE: prdata = {16'd0, full_r};
      bbcc_pkg::REG_BATTERY_HIGH:   prdata = {16'd0, bat_high_r};
      bbcc_pkg::REG_BALANCE_HIGH:   prdata = {16'd0, bal_high_r};
      bbcc_pkg::REG_INPUT_MIN:      prdata = {16'd0, in_min_r};
      bbcc_pkg::REG_START_HOLD:     prdata = {16'd0, start_hold_r};
      bbcc_pkg::REG_OUTPUT_MIN:     prdata = {16'd0, out_min_r};
      default:                      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Handshake. The input register drains into the result register whenever
  // the result register is empty or being taken this cycle, and it refills
  // in the same cycle, so a full pipeline still moves one request per clock.
  // ---------------------------------------------------------------------
  assign s0_adv      = s0_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s0_valid_r || s0_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s0_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s0_vin_r    <= in_ch.input_mv;
      s0_vbat_r   <= in_ch.battery_mv;
      s0_vbal_r   <= in_ch.balance_mv;
      s0_sense_r  <= in_ch.sense_mv;
      s0_temp_r   <= in_ch.chip_temp_mc;
      s0_wanted_r <= in_ch.output_wanted;
    end
  end

  // ---------------------------------------------------------------------
  // Tick logic. The phase advances first; the search sees the new phase.
  // ---------------------------------------------------------------------
  always_comb begin
    phase_nxt = (phase_r >= bbcc_pkg::PHASE_LAST) ? '0 : phase_r + 7'd1;

    // Safety and charge-window checks.
    charging = (s0_vbat_r >= bbcc_pkg::BATTERY_FLOOR_MV) && (s0_vbat_r <= bat_high_r) &&
               (s0_vbal_r <= bal_high_r) && (s0_vin_r >= in_min_r) &&
               (s0_temp_r <= bbcc_pkg::TEMP_LIMIT_MC);

    // Settle pause: a high input restarts it, then it counts up to 26.
    settled    = settle_r > bbcc_pkg::SETTLE_TICKS;
    settle_nxt = (s0_vin_r > start_hold_r) ? 5'd1 : settle_r + 5'd1;

    // Measured current, which can go negative below the sense offset.
    cur = $signed({2'b00, s0_sense_r}) - bbcc_pkg::SENSE_OFFSET_MV;
    tgt = $signed({2'b00, target_r});

    // The search runs on the boost pulse while buck is pinned at full scale.
    p     = (buck_r == full_r) ? boost_r : buck_r;
    p_inc = p + 16'd1;
    p_dec = (p == '0) ? '0 : p - 16'd1;

    // p < full/3 is the same as 3*(p+1) <= full, so no divider is needed.
    p1         = {2'b00, p} + 18'd1;
    p1x3       = p1 + {p1[bbcc_pkg::PULSE_W:0], 1'b0};
    low_room   = p1x3 <= {2'b00, full_r};
    climb_room = p < (full_r - {2'b00, full_r[bbcc_pkg::MV_W-1:2]});

    bc    = {best_cur_r[bbcc_pkg::BEST_W-1], best_cur_r};
    bp    = best_pulse_r;
    p_new = p;

    if (cur > tgt) begin
      p_new = p_dec;
    end else if ((cur < bbcc_pkg::LOW_CURRENT_MV) && low_room) begin
      p_new = p_inc;
    end else begin
      // Sitting on the best pulse refreshes its record so that a fresh
      // reading there is not beaten by a stale one.
      if (p == bp) begin
        bc = cur + 14'sd1;
      end
      case (phase_nxt)
        7'd1, 7'd3, 7'd5, 7'd7: begin
          // Climb phases: step up until close to the target.
          if (cur > bc) begin
            bc = cur;
            bp = p;
          end
          if (cur > tgt - bbcc_pkg::NEAR_TARGET_MV) begin
            p_new = p;
          end else if (climb_room) begin
            p_new = p_inc;
          end
        end
        7'd51, 7'd53, 7'd55, 7'd57: begin
          // Descent phases: ties move the record to the lower pulse.
          if (cur >= bc) begin
            bc = cur;
            bp = p;
          end
          if (p > 16'd1) begin
            p_new = p_dec;
          end
        end
        7'd9, 7'd59: begin
          if (cur > bc) begin
            bc = cur;
            bp = p;
          end
        end
        7'd10, 7'd60: begin
          p_new = best_pulse_r;
        end
        default: ;
      endcase
    end

    // Boost when the battery sits clearly above the input, buck otherwise.
    boost_mode = {1'b0, s0_vbat_r} > ({1'b0, s0_vin_r} + bbcc_pkg::BOOST_MARGIN_MV);

    buck_nxt  = buck_r;
    boost_nxt = boost_r;
    if (!charging) begin
      buck_nxt  = '0;
      boost_nxt = '0;
    end else if (settled) begin
      buck_nxt  = boost_mode ? full_r : p_new;
      boost_nxt = boost_mode ? p_new : '0;
    end

    conv_on = s0_wanted_r && (buck_nxt == '0) && (boost_nxt == '0) &&
              (s0_vbat_r >= out_min_r);
    off_nxt = conv_on ? '0 : ((&off_cnt_r) ? off_cnt_r : off_cnt_r + 32'd1);
  end

  // Controller state, updated once per request as it leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= '0;
      settle_r     <= '0;
      buck_r       <= '0;
      boost_r      <= '0;
      best_cur_r   <= '0;
      best_pulse_r <= '0;
      off_cnt_r    <= '0;
    end else if (s0_adv) begin
      phase_r   <= phase_nxt;
      buck_r    <= buck_nxt;
      boost_r   <= boost_nxt;
      off_cnt_r <= off_nxt;
      if (!charging) begin
        settle_r     <= '0;
        best_cur_r   <= '0;
        best_pulse_r <= '0;
      end else if (settled) begin
        best_cur_r   <= bc[bbcc_pkg::BEST_W-1:0];
        best_pulse_r <= bp;
      end else begin
        settle_r <= settle_nxt;
      end
    end
  end

  // Result register: holds its value until the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s0_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_adv) begin
      out_buck_r  <= buck_nxt;
      out_boost_r <= boost_nxt;
      out_conv_r  <= conv_on;
      out_chg_r   <= charging;
      out_off_r   <= off_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.buck_pulse   = out_buck_r;
  assign out_ch.boost_pulse  = out_boost_r;
  assign out_ch.converter_on = out_conv_r;
  assign out_ch.charging     = out_chg_r;
  assign out_ch.off_ticks    = out_off_r;

`ifndef SYNTH
  // The phase never leaves 0..99 and the settle count never passes 26.
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= bbcc_pkg::PHASE_LAST)
    else $error("phase counter out of range");

  a_settle_range: assert property (@(posedge clk) disable iff (!rst_n)
    settle_r <= bbcc_pkg::SETTLE_TICKS + 5'd1)
    else $error("settle counter out of range");

  // A tick that fails the charge checks leaves both pulses cleared.
  a_fault_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s0_adv && !charging |=> (buck_r == '0) && (boost_r == '0))
    else $error("pulses not cleared after a failed charge check");

  // Every request leaving the input register shows up as a result, and an
  // enabled converter comes with a zero off count and no pulses.
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    s0_adv |=> out_valid_r && (!out_conv_r ||
      (out_off_r == '0 && out_buck_r == '0 && out_boost_r == '0)))
    else $error("result register not loaded consistently");
`endif

endmodule
